// ===== design/mlrr_pkg.sv =====
// Shared types and constants for the multilevel round-robin scheduler.
`timescale 1ns / 1ps
package mlrr_pkg;
	localparam int NUM_LEVELS = 4;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_ID_WIDTH = 16;
	localparam int OUT_ID_WIDTH = 16;
	localparam int QUANTUM_WIDTH = 8;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_SERVE = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] CFG_Q1 = 2'd0;
	localparam logic [1:0] CFG_Q2 = 2'd1;
	localparam logic [1:0] CFG_Q3 = 2'd2;
	localparam logic [1:0] CFG_Q4 = 2'd3;

	// per-level operation driven into a queue row
	typedef struct packed {
		logic append;   // write id at tail
		logic remove;   // delete first match
		logic rotate;   // head to tail
	} lvl_op_t;
endpackage

// ===== design/mlrr_cell.sv =====
// One slot of a level queue: holds an id and shifts toward the head.
`timescale 1ns / 1ps
module mlrr_cell import mlrr_pkg::*; #(
	parameter int ID_WIDTH = DEF_ID_WIDTH
) (
	input  logic                clk,
	input  logic                load,      // write new_id
	input  logic                shift,     // take neighbor's id
	input  logic [ID_WIDTH-1:0] new_id,
	input  logic [ID_WIDTH-1:0] next_id,   // from the cell behind
	input  logic [ID_WIDTH-1:0] probe_id,
	output logic [ID_WIDTH-1:0] id_q,
	output logic                hit
);
	always_ff @(posedge clk) begin
		if (load) begin
			id_q <= new_id;
		end else if (shift) begin
			id_q <= next_id;
		end
	end
	assign hit = (id_q == probe_id);
endmodule

// ===== design/mlrr_level.sv =====
// One priority level: a row of cells with a fill count.
`timescale 1ns / 1ps
module mlrr_level import mlrr_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_WIDTH = DEF_ID_WIDTH,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lvl_op_t             op,
	input  logic [ID_WIDTH-1:0] probe_id,
	output logic [CW-1:0]       count_q,
	output logic                found,     // valid match in row
	output logic [ID_WIDTH-1:0] head_id
);
	logic [ID_WIDTH-1:0] ids [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] hits, valid, first_hit, at_or_after;
	logic [QUEUE_DEPTH-1:0] load, shift;
	logic [ID_WIDTH-1:0] wr_id;

	assign head_id = ids[0];
	assign first_hit = (hits & valid) & ~((hits & valid) - 1'b1);
	assign found = |(hits & valid);
	// cells at or beyond the first match
	assign at_or_after = ~(first_hit - 1'b1);
	assign wr_id = op.rotate ? ids[0] : probe_id;

	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			logic [ID_WIDTH-1:0] nxt;
			logic is_tail;
			if (g == QUEUE_DEPTH - 1) begin : g_end
				assign nxt = ids[g];
			end else begin : g_mid
				assign nxt = ids[g+1];
			end
			assign valid[g] = (CW'(g) < count_q);
			assign is_tail = (CW'(g) == (op.rotate ? count_q - 1'b1 : count_q));
			assign load[g] = (op.append || op.rotate) && is_tail;
			assign shift[g] = (op.rotate && valid[g]) || (op.remove && at_or_after[g]);
			mlrr_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
				.clk      (clk),
				.load     (load[g]),
				.shift    (shift[g]),
				.new_id   (wr_id),
				.next_id  (nxt),
				.probe_id (probe_id),
				.id_q     (ids[g]),
				.hit      (hits[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op.append) begin
			count_q <= count_q + 1'b1;
		end else if (op.remove) begin
			count_q <= count_q - 1'b1;
		end
	end
endmodule

// ===== design/multilevel_round_robin_scheduler.sv =====
// Top level: four cell-chain level queues, command decode and result register.
// Results: the row search/update runs in the cycle an item is accepted, and its
// result is held in an output register, valid in the cycle after.
// Intake: a new item is taken only while the busy guard set by the last item is
// clear and the result register is empty or being drained, so row updates settle.
// Reset: counts clear, rotation points at level one, quanta load 4,3,2,1;
// stored ids are not cleared.
`timescale 1ns / 1ps
module multilevel_round_robin_scheduler import mlrr_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_WIDTH = DEF_ID_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               cmd,
	input  logic [15:0]              proc_id,
	input  logic [2:0]               level,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok,
	output logic [15:0]              served_id,
	output logic [7:0]               slice,
	output logic                     any_queued,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [7:0]               cfg_data
);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [7:0] quanta_q [NUM_LEVELS];
	logic [1:0] rot_q;
	logic       busy_q;     // one cycle guard after a row update
	logic       take;
	logic [ID_WIDTH-1:0] probe;
	lvl_op_t    ops [NUM_LEVELS];
	logic [CW-1:0] cnt [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] found, nonempty, full, srv_sel, rm_sel;
	logic [ID_WIDTH-1:0] heads [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] rot_mask, cand;
	logic [1:0] srv_lvl;
	logic       srv_ok;
	logic [1:0] add_lvl;
	logic       add_ok, rm_ok, res_ok;
	logic [NUM_LEVELS-1:0] cnt_after;

	// accept when the output slot is free or draining, and no row is mid-update
	assign in_stall = busy_q || (out_valid && out_stall);
	assign take = in_valid && !in_stall;
	assign probe = ID_WIDTH'(proc_id);
	assign add_lvl = 2'(level - 3'd1);

	genvar g;
	generate
		for (g = 0; g < NUM_LEVELS; g++) begin : g_lvl
			assign nonempty[g] = (cnt[g] != '0);
			assign full[g] = (cnt[g] == CW'(QUEUE_DEPTH));
			assign rot_mask[g] = (2'(g) >= rot_q);
			mlrr_level #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_WIDTH(ID_WIDTH)) u_lvl (
				.clk      (clk),
				.arst_n   (arst_n),
				.op       (ops[g]),
				.probe_id (probe),
				.count_q  (cnt[g]),
				.found    (found[g]),
				.head_id  (heads[g])
			);
		end
	endgenerate

	// serve: first non-empty level from the pointer, wrapping
	always_comb begin
		cand = nonempty & rot_mask;
		if (cand == '0) cand = nonempty;
		srv_ok = |nonempty;
		srv_lvl = 2'd0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (cand[i]) srv_lvl = 2'(i);
		end
		rm_sel = found & ~(found - 1'b1);
		rm_ok = |found;
		add_ok = (level >= 3'd1) && (level <= 3'd4) && !full[add_lvl];
		srv_sel = '0;
		srv_sel[srv_lvl] = srv_ok;
		res_ok = 1'b0;
		unique case (cmd)
			CMD_ADD:    res_ok = add_ok;
			CMD_REMOVE: res_ok = rm_ok;
			CMD_SERVE:  res_ok = srv_ok;
			default:    res_ok = 1'b0;
		endcase
		for (int i = 0; i < NUM_LEVELS; i++) begin
			ops[i].append = take && (cmd == CMD_ADD) && add_ok && (add_lvl == 2'(i));
			ops[i].remove = take && (cmd == CMD_REMOVE) && rm_sel[i];
			ops[i].rotate = take && (cmd == CMD_SERVE) && srv_sel[i];
			cnt_after[i] = ops[i].remove ? (cnt[i] > CW'(1)) :
				(nonempty[i] || ops[i].append);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= 2'd0;
			busy_q <= 1'b0;
			out_valid <= 1'b0;
			quanta_q[0] <= 8'd4;
			quanta_q[1] <= 8'd3;
			quanta_q[2] <= 8'd2;
			quanta_q[3] <= 8'd1;
		end else begin
			busy_q <= take;
			if (take) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (take && (cmd == CMD_SERVE) && srv_ok) begin
				rot_q <= srv_lvl + 2'd1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_Q1: quanta_q[0] <= cfg_data;
					CFG_Q2: quanta_q[1] <= cfg_data;
					CFG_Q3: quanta_q[2] <= cfg_data;
					CFG_Q4: quanta_q[3] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			ok <= res_ok;
			any_queued <= |cnt_after;
			if (cmd == CMD_SERVE && srv_ok) begin
				served_id <= 16'(heads[srv_lvl]);
				slice <= quanta_q[srv_lvl];
			end else begin
				served_id <= '0;
				slice <= '0;
			end
		end
	end
endmodule
